[hdl/deq_pkg.sv]
// Shared constants, command types and status codes for the double-ended queue unit.
`default_nettype none
package deq_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int ELEM_W     = 32;
    localparam int STAT_W     = 2;
    localparam int CMD_QD     = 4;
    localparam int CQ_PTR_W   = $clog2(CMD_QD);
    localparam int CQ_CNT_W   = $clog2(CMD_QD + 1);

    typedef enum logic [ACT_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_READ_ALL  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] data;
    } t_cmd;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage
`default_nettype wire

[hdl/deq_front.sv]
// Front end: accepts input words, decodes the action and drops unused codes.
`default_nettype none
module deq_front (
    input  wire logic                           i_push,
    input  wire logic [deq_pkg::ACT_W-1:0]      i_action,
    input  wire logic signed [deq_pkg::ELEM_W-1:0] i_value,
    input  wire logic                           i_q_full,
    output logic                                o_full,
    output logic                                o_wr,
    output deq_pkg::t_cmd                       o_cmd
);

    logic signed [63:0] w_val64;
    logic               w_known;

    assign w_val64 = 64'(i_value);
    assign o_full  = i_q_full;

    always_comb begin
        case (i_action)
            deq_pkg::OP_INS_FRONT, deq_pkg::OP_INS_REAR,
            deq_pkg::OP_DEL_FRONT, deq_pkg::OP_DEL_REAR,
            deq_pkg::OP_READ_ALL: begin
                w_known = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_wr       = i_push && !i_q_full && w_known;
    assign o_cmd.op   = deq_pkg::t_op'(i_action);
    assign o_cmd.data = w_val64[deq_pkg::DATA_WIDTH-1:0];

endmodule
`default_nettype wire

[hdl/deq_cmd_fifo.sv]
// Short command queue that decouples the front end from the ring controller.
`default_nettype none
module deq_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire deq_pkg::t_cmd i_cmd,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_valid,
    output deq_pkg::t_cmd      o_cmd
);

    deq_pkg::t_cmd                    r_slot [deq_pkg::CMD_QD];
    logic [deq_pkg::CQ_PTR_W-1:0]     r_wp;
    logic [deq_pkg::CQ_PTR_W-1:0]     r_rp;
    logic [deq_pkg::CQ_CNT_W-1:0]     r_cnt;
    logic                             w_do_rd;

    assign o_full  = (r_cnt == deq_pkg::CQ_CNT_W'(deq_pkg::CMD_QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == deq_pkg::CQ_PTR_W'(deq_pkg::CMD_QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_rd) begin
                r_rp <= (r_rp == deq_pkg::CQ_PTR_W'(deq_pkg::CMD_QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_wr && !w_do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && w_do_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/deq_back.sv]
// Back end: ring storage, front index and occupancy, command execution and result register.
`default_nettype none
module deq_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire deq_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_rd,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic signed [deq_pkg::ELEM_W-1:0]  o_element,
    output logic [deq_pkg::STAT_W-1:0]         o_status,
    output logic                               o_last
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } t_state;

    localparam int SUM_W = deq_pkg::CNT_W + 1;

    function automatic logic [deq_pkg::IDX_W-1:0] ring_add(
        input logic [deq_pkg::IDX_W-1:0] base,
        input logic [deq_pkg::CNT_W-1:0] off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(deq_pkg::DEPTH)) begin
            sum = sum - SUM_W'(deq_pkg::DEPTH);
        end
        return sum[deq_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [deq_pkg::ELEM_W-1:0] widen(
        input logic [deq_pkg::DATA_WIDTH-1:0] w
    );
        logic signed [63:0] x;
        x = 64'(signed'(w));
        return x[deq_pkg::ELEM_W-1:0];
    endfunction

    logic [deq_pkg::DATA_WIDTH-1:0] r_mem [deq_pkg::DEPTH];
    logic [deq_pkg::DATA_WIDTH-1:0] r_rd_data;

    t_state                      r_state, n_state;
    logic [deq_pkg::IDX_W-1:0]   r_front, n_front;
    logic [deq_pkg::CNT_W-1:0]   r_occ, n_occ;
    logic [deq_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic                        r_pend_last, n_pend_last;
    logic                        r_out_valid, n_out_valid;
    logic [deq_pkg::ELEM_W-1:0]  r_elem, n_elem;
    logic [deq_pkg::STAT_W-1:0]  r_stat, n_stat;
    logic                        r_last, n_last;

    logic                        w_we;
    logic [deq_pkg::IDX_W-1:0]   w_wr_addr;
    logic                        w_re;
    logic [deq_pkg::IDX_W-1:0]   w_rd_addr;
    logic                        w_out_free;
    logic                        w_is_full;
    logic                        w_is_empty;
    logic                        w_tail;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_is_full  = (r_occ == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign w_is_empty = (r_occ == '0);
    assign w_tail     = ((deq_pkg::CNT_W'(r_idx) + 1'b1) == r_occ);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_elem      = r_elem;
        n_stat      = r_stat;
        n_last      = r_last;
        w_we        = 1'b0;
        w_wr_addr   = r_front;
        w_re        = 1'b0;
        w_rd_addr   = ring_add(r_front, deq_pkg::CNT_W'(r_idx));
        o_cmd_rd    = 1'b0;

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        if (r_pend) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
            n_elem      = widen(r_rd_data);
            n_stat      = deq_pkg::STAT_OK;
            n_last      = r_pend_last;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_pend && w_out_free) begin
                    o_cmd_rd = 1'b1;
                    n_elem   = '0;
                    n_last   = 1'b1;
                    case (i_cmd.op)
                        deq_pkg::OP_INS_FRONT, deq_pkg::OP_INS_REAR: begin
                            n_out_valid = 1'b1;
                            if (w_is_full) begin
                                n_stat = deq_pkg::STAT_FULL;
                            end else begin
                                n_stat = deq_pkg::STAT_OK;
                                n_occ  = r_occ + 1'b1;
                                w_we   = 1'b1;
                                if (i_cmd.op == deq_pkg::OP_INS_FRONT) begin
                                    w_wr_addr = (r_front == '0) ?
                                        deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : r_front - 1'b1;
                                    n_front   = w_wr_addr;
                                end else begin
                                    w_wr_addr = ring_add(r_front, r_occ);
                                end
                            end
                        end
                        deq_pkg::OP_DEL_FRONT, deq_pkg::OP_DEL_REAR: begin
                            n_out_valid = 1'b1;
                            if (w_is_empty) begin
                                n_stat = deq_pkg::STAT_EMPTY;
                            end else begin
                                n_stat = deq_pkg::STAT_OK;
                                n_occ  = r_occ - 1'b1;
                                if (i_cmd.op == deq_pkg::OP_DEL_FRONT) begin
                                    n_front = ring_add(r_front, deq_pkg::CNT_W'(1));
                                end
                            end
                        end
                        deq_pkg::OP_READ_ALL: begin
                            if (w_is_empty) begin
                                n_out_valid = 1'b1;
                                n_stat      = deq_pkg::STAT_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_STREAM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (!r_pend && w_out_free) begin
                    w_re        = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = w_tail;
                    n_idx       = r_idx + 1'b1;
                    if (w_tail) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= i_cmd.data;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        r_stat <= n_stat;
        r_last <= n_last;
    end

    assign o_empty   = !r_out_valid;
    assign o_element = r_elem;
    assign o_status  = r_stat;
    assign o_last    = r_last;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("occupancy exceeds ring depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= deq_pkg::IDX_W'(deq_pkg::DEPTH - 1))
        else $error("front index out of range");

    a_pend_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("ring read did not reach the result register");

    a_stream_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |=> ($stable(r_occ) && $stable(r_front)))
        else $error("ring state changed during read all");

    a_stream_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_occ != '0))
        else $error("read all streaming from an empty ring");
`endif

endmodule
`default_nettype wire

[hdl/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit: front end, command queue and ring controller.
//
//  Channel  | Handshake            | Words
//  ---------+----------------------+---------------------------------
//  input    | i_push / o_full      | i_action, i_value
//  result   | o_empty / i_pop      | o_element, o_status, o_last
//
//  Inserts and deletes are executed by the ring controller once the result register
//  is free; read all passes each element through the registered ring memory read.
//  A four-word command queue lets input words be taken while results wait to be popped.
//  Unused action codes are taken and discarded. Reset is synchronous; the block is ready
//  in the cycle after reset and needs no clearing pass.
`default_nettype none
module double_ended_queue_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic [deq_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [deq_pkg::ELEM_W-1:0] i_value,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic signed [deq_pkg::ELEM_W-1:0]      o_element,
    output logic [deq_pkg::STAT_W-1:0]             o_status,
    output logic                                   o_last
);

    logic           w_q_full;
    logic           w_wr;
    deq_pkg::t_cmd  w_wr_cmd;
    logic           w_q_valid;
    deq_pkg::t_cmd  w_q_cmd;
    logic           w_q_rd;

    deq_front u_front (
        .i_push   (i_push),
        .i_action (i_action),
        .i_value  (i_value),
        .i_q_full (w_q_full),
        .o_full   (o_full),
        .o_wr     (w_wr),
        .o_cmd    (w_wr_cmd)
    );

    deq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_wr_cmd),
        .i_rd    (w_q_rd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    deq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_rd    (w_q_rd),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_element   (o_element),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
